>>> src/byte_stuffing_frame_transmitter_assert.svh
// Assertion macros shared by the framer checker
`ifndef BYTE_STUFFING_FRAME_TRANSMITTER_ASSERT_SVH
`define BYTE_STUFFING_FRAME_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define BSFT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");

// Next-cycle implication, quiet while reset is high
`define BSFT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");

`endif

>>> src/bsft_pkg.sv
// Shared types and constants of the byte stuffing framer
`default_nettype none
package bsft_pkg;

   localparam int BYTE_W     = 8;
   localparam int LIST_DEPTH = 9;
   localparam int LIST_IDX_W = $clog2(LIST_DEPTH + 1);
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FLAG     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_ZERO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_ONE  = 3'd5;

   localparam logic [BYTE_W-1:0] RST_FLAG      = 8'h7E;
   localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'h7D;
   localparam logic [BYTE_W-1:0] RST_MASK      = 8'h20;
   localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'h03;
   localparam logic [BYTE_W-1:0] RST_CTRL_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] RST_CTRL_ONE  = 8'h40;

   typedef struct packed {
      logic [BYTE_W-1:0] flag;
      logic [BYTE_W-1:0] escape;
      logic [BYTE_W-1:0] mask;
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] ctrl_zero;
      logic [BYTE_W-1:0] ctrl_one;
   } csr_type;

   // Line words produced by one payload word
   typedef struct packed {
      logic [LIST_DEPTH-1:0][BYTE_W-1:0] bytes;
      logic [LIST_IDX_W-1:0]             count;
      logic                              closes_frame;
   } word_list_type;

endpackage
`default_nettype wire

>>> src/bsft_channels.sv
// Handshake interfaces for the payload and line channels
`default_nettype none
interface bsft_req_if;
   logic                      valid;
   logic                      ready;
   logic [bsft_pkg::BYTE_W-1:0] payload_byte;
   logic                      final_byte;
   logic                      sequence_bit;

   modport source (output valid, payload_byte, final_byte, sequence_bit, input ready);
   modport sink   (input valid, payload_byte, final_byte, sequence_bit, output ready);
endinterface

interface bsft_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bsft_pkg::BYTE_W-1:0] line_byte;
   logic                      frame_done;
   logic                      run_last;

   modport source (output valid, line_byte, frame_done, run_last, input ready);
   modport sink   (input valid, line_byte, frame_done, run_last, output ready);
endinterface
`default_nettype wire

>>> src/bsft_csr.sv
// Configuration register file of the framer
`default_nettype none
module bsft_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [bsft_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bsft_pkg::BYTE_W-1:0]    csr_write_data,
   output bsft_pkg::csr_type                   cfg
);

   bsft_pkg::csr_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.flag      <= bsft_pkg::RST_FLAG;
         regs_ff.escape    <= bsft_pkg::RST_ESCAPE;
         regs_ff.mask      <= bsft_pkg::RST_MASK;
         regs_ff.address   <= bsft_pkg::RST_ADDRESS;
         regs_ff.ctrl_zero <= bsft_pkg::RST_CTRL_ZERO;
         regs_ff.ctrl_one  <= bsft_pkg::RST_CTRL_ONE;
      end else if (csr_write_en) begin
         case (csr_index)
            bsft_pkg::CSR_FLAG:      regs_ff.flag      <= csr_write_data;
            bsft_pkg::CSR_ESCAPE:    regs_ff.escape    <= csr_write_data;
            bsft_pkg::CSR_MASK:      regs_ff.mask      <= csr_write_data;
            bsft_pkg::CSR_ADDRESS:   regs_ff.address   <= csr_write_data;
            bsft_pkg::CSR_CTRL_ZERO: regs_ff.ctrl_zero <= csr_write_data;
            bsft_pkg::CSR_CTRL_ONE:  regs_ff.ctrl_one  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg = regs_ff;

endmodule
`default_nettype wire

>>> src/bsft_expand.sv
// Expands a payload word: header if first, stuffed payload, trailer if final
`default_nettype none
module bsft_expand (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  bsft_pkg::csr_type                cfg,
   input  wire logic [bsft_pkg::BYTE_W-1:0] payload_byte,
   input  wire logic                        final_byte,
   input  wire logic                        sequence_bit,
   input  wire logic                        accept,
   output bsft_pkg::word_list_type          list
);

   logic                        inside_frame_ff;
   logic                        inside_frame_in;
   logic [bsft_pkg::BYTE_W-1:0] check_ff;
   logic [bsft_pkg::BYTE_W-1:0] check_in;
   logic [bsft_pkg::BYTE_W-1:0] ctrl;
   logic [bsft_pkg::BYTE_W-1:0] new_check;
   logic                        pay_esc;
   logic                        chk_esc;
   logic [bsft_pkg::LIST_IDX_W-1:0] n;

   assign ctrl      = sequence_bit ? cfg.ctrl_one : cfg.ctrl_zero;
   assign new_check = (inside_frame_ff ? check_ff : '0) ^ payload_byte;
   assign pay_esc   = (payload_byte == cfg.flag) || (payload_byte == cfg.escape);
   assign chk_esc   = (new_check == cfg.flag) || (new_check == cfg.escape);

   // Append words in order; n is the next free slot
   always_comb begin
      list.bytes        = '0;
      list.closes_frame = final_byte;
      n                 = '0;
      if (!inside_frame_ff) begin
         list.bytes[0] = cfg.flag;
         list.bytes[1] = cfg.address;
         list.bytes[2] = ctrl;
         list.bytes[3] = cfg.address ^ ctrl;
         n             = bsft_pkg::LIST_IDX_W'(4);
      end
      if (pay_esc) begin
         list.bytes[n]                                = cfg.escape;
         list.bytes[bsft_pkg::LIST_IDX_W'(n + 1'b1)]  = payload_byte ^ cfg.mask;
         n = bsft_pkg::LIST_IDX_W'(n + 2'd2);
      end else begin
         list.bytes[n] = payload_byte;
         n = bsft_pkg::LIST_IDX_W'(n + 1'b1);
      end
      if (final_byte) begin
         if (chk_esc) begin
            list.bytes[n]                               = cfg.escape;
            list.bytes[bsft_pkg::LIST_IDX_W'(n + 1'b1)] = new_check ^ cfg.mask;
            n = bsft_pkg::LIST_IDX_W'(n + 2'd2);
         end else begin
            list.bytes[n] = new_check;
            n = bsft_pkg::LIST_IDX_W'(n + 1'b1);
         end
         list.bytes[n] = cfg.flag;
         n = bsft_pkg::LIST_IDX_W'(n + 1'b1);
      end
      list.count = n;
   end

   assign inside_frame_in = accept ? !final_byte : inside_frame_ff;
   assign check_in        = accept ? (final_byte ? '0 : new_check) : check_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_frame_ff <= 1'b0;
         check_ff        <= '0;
      end else begin
         inside_frame_ff <= inside_frame_in;
         check_ff        <= check_in;
      end
   end

endmodule
`default_nettype wire

>>> src/bsft_emit.sv
// Holds one word list and sends it out one line word per cycle while the output is not stalled
`default_nettype none
module bsft_emit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  bsft_pkg::word_list_type           list_in,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   output logic                              accept,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [bsft_pkg::BYTE_W-1:0]       rsp_line_byte,
   output logic                              rsp_frame_done,
   output logic                              rsp_run_last
);

   bsft_pkg::word_list_type         list_ff;
   logic [bsft_pkg::LIST_IDX_W-1:0] idx_ff;
   logic                            busy_ff;
   logic                            valid_ff;
   logic [bsft_pkg::BYTE_W-1:0]     byte_ff;
   logic                            done_ff;
   logic                            last_ff;
   logic                            out_load;
   logic                            move;
   logic                            at_end;

   assign out_load  = !valid_ff || rsp_ready;
   assign move      = busy_ff && out_load;
   assign at_end    = (idx_ff == bsft_pkg::LIST_IDX_W'(list_ff.count - 1'b1));
   assign req_ready = !busy_ff || (move && at_end);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (move) begin
            idx_ff <= bsft_pkg::LIST_IDX_W'(idx_ff + 1'b1);
            if (at_end) begin
               busy_ff <= 1'b0;
            end
         end
         if (move) begin
            valid_ff <= 1'b1;
         end else if (out_load) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         list_ff <= list_in;
      end
      if (move) begin
         byte_ff <= list_ff.bytes[idx_ff];
         last_ff <= at_end;
         done_ff <= at_end && list_ff.closes_frame;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_line_byte  = byte_ff;
   assign rsp_frame_done = done_ff;
   assign rsp_run_last   = last_ff;

endmodule
`default_nettype wire

>>> src/byte_stuffing_frame_transmitter.sv
// Top level of the byte stuffing frame transmitter
//
//   channel   dir   handshake        word contents
//   req_bus   in    valid / ready    payload_byte, final_byte, sequence_bit
//   rsp_bus   out   valid / ready    line_byte, frame_done, run_last
//   csr_*     in    write enable     csr_index, csr_write_data
//
// A payload word turns into 1 to 9 line words: 4 header words on the first word of a
// frame, 1 or 2 for the stuffed payload, and on the final word 1 or 2 for the stuffed
// check plus the closing flag. One line word leaves the output register per cycle
// while rsp_bus is not stalled.
// Reset is synchronous; it restores the register defaults, closes any open frame and
// drops the output valid.
// A stalled rsp_bus holds the output word; the next payload word is taken in the same
// cycle that the last line word of the current one moves to the output register.
`default_nettype none
module byte_stuffing_frame_transmitter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bsft_req_if.sink                            req_bus,
   bsft_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_write_en,
   input  wire logic [bsft_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bsft_pkg::BYTE_W-1:0]    csr_write_data
);

   bsft_pkg::csr_type       cfg;
   bsft_pkg::word_list_type list;
   logic                    accept;

   // Configuration registers; the user must write them only while the block is idle, the block does not enforce it
   bsft_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // Build the full line word list of the incoming payload word and advance the
   // frame state (open flag, running check) when the word is taken
   bsft_expand u_expand (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .payload_byte (req_bus.payload_byte),
      .final_byte   (req_bus.final_byte),
      .sequence_bit (req_bus.sequence_bit),
      .accept       (accept),
      .list         (list)
   );

   // Hold the list and drain it into the output register, one word per cycle while rsp_bus is not stalled
   bsft_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .list_in        (list),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .accept         (accept),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_line_byte  (rsp_bus.line_byte),
      .rsp_frame_done (rsp_bus.frame_done),
      .rsp_run_last   (rsp_bus.run_last)
   );

endmodule
`default_nettype wire

>>> src/bsft_checker.sv
// Port-level checks of the framer and their bind
`default_nettype none
`include "byte_stuffing_frame_transmitter_assert.svh"
module bsft_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [bsft_pkg::BYTE_W-1:0] rsp_line_byte,
   input wire logic                        rsp_frame_done,
   input wire logic                        rsp_run_last
);

   logic rsp_take;
   logic req_take_held;

   assign rsp_take      = rsp_valid && rsp_ready;
   assign req_take_held = req_valid && req_ready && rsp_valid && !rsp_ready;

   // closing flag always ends the run of its payload word
   `BSFT_ASSERT_NOW(a_done_is_last, clock, reset, rsp_valid && rsp_frame_done, rsp_run_last)

   // a run keeps flowing without gaps until its last word
   `BSFT_ASSERT_NEXT(a_run_no_gap, clock, reset, rsp_take && !rsp_run_last, rsp_valid)

   // no new payload word taken during an output stall while the run still has words after the one shown
   `BSFT_ASSERT_NOW(a_no_take_mid_run, clock, reset, req_take_held, rsp_run_last)

   // stalled output word holds
   `BSFT_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_line_byte))

endmodule

bind byte_stuffing_frame_transmitter bsft_checker u_bsft_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_line_byte  (rsp_bus.line_byte),
   .rsp_frame_done (rsp_bus.frame_done),
   .rsp_run_last   (rsp_bus.run_last)
);
`default_nettype wire
